FILE: hdl/focft_pkg.sv
// Package for the FOC frame transform pipeline: widths, payload structs,
// the quarter-wave sine table and the saturation helper.
// Depends on nothing; used by every module under hdl.
package focft_pkg;

  localparam int SAMPLE_WIDTH     = 16;
  localparam int ANGLE_WIDTH      = 16;
  localparam int SINE_TABLE_DEPTH = 256;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int FB    = ANGLE_WIDTH - 2;
  localparam int TW    = 17;
  localparam int KW    = 21;
  localparam int Q_K   = 20;
  localparam int Q_T   = 15;
  localparam int IW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int DB    = $clog2(SINE_TABLE_DEPTH) + 1;
  localparam int UW    = SW + 2;
  localparam int VW    = SW + 1;
  localparam int PUW   = UW + KW;
  localparam int PVW   = VW + KW;
  localparam int MW    = SW + TW;
  localparam int XSW   = MW + 1;
  localparam int XW    = SW + 2;
  localparam int PRW   = XW + TW;
  localparam int DSW   = PRW + 1;
  localparam int DRAW  = DSW - Q_T;
  localparam int PKW   = XW + KW;
  localparam int PBW   = PKW + 1;
  localparam int PHW   = SW + 3;
  localparam int DRW   = PHW + 2;
  localparam int SATW  = SW + 8;

  localparam int NSTAGE       = 6;
  localparam int FRONT_STAGES = 3;
  localparam int BACK_STAGES  = NSTAGE - FRONT_STAGES;

  localparam longint RND_K = longint'(1) <<< (Q_K - 1);
  localparam longint RND_T = longint'(1) <<< (Q_T - 1);
  localparam longint SAT_HI = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  localparam logic signed [KW-1:0] K_SQRT_1_6 = KW'(428079);
  localparam logic signed [KW-1:0] K_SQRT_1_2 = KW'(741455);
  localparam logic signed [KW-1:0] K_SQRT_2_3 = KW'(856159);

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TRIG_ONE    = 64'sd32768;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef logic signed [TW-1:0] trig_t;
  typedef trig_t sine_rom_t [0:SINE_TABLE_DEPTH];

  typedef struct packed {
    logic signed [SW-1:0]  current_a;
    logic signed [SW-1:0]  current_b;
    logic signed [SW-1:0]  current_c;
    logic [ANGLE_WIDTH-1:0] rotor_angle;
    logic signed [SW-1:0]  volt_d;
    logic signed [SW-1:0]  volt_q;
  } in_t;

  typedef struct packed {
    logic signed [SW-1:0] current_d;
    logic signed [SW-1:0] current_q;
    logic signed [SW-1:0] drive_a;
    logic signed [SW-1:0] drive_b;
    logic signed [SW-1:0] drive_c;
  } out_t;

  typedef struct packed {
    logic signed [XW-1:0] alpha;
    logic signed [XW-1:0] beta;
    logic signed [XW-1:0] volt_x;
    logic signed [XW-1:0] volt_y;
    trig_t                sine;
    trig_t                cosine;
  } mid_t;

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint x;
    longint x2;
    longint term;
    longint sum;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >>> 30) / 64'sd6;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 64'sd20;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 64'sd42;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 64'sd72;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 64'sd110;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 64'sd156;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 64'sd210;
      sum  = sum - term;
      if (sum < 0) begin
        sum = 0;
      end
      sum = (sum + (longint'(1) <<< 14)) >>> 15;
      if (sum > TRIG_ONE) begin
        sum = TRIG_ONE;
      end
      rom[k] = TW'(sum);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  function automatic logic signed [SW-1:0] saturate(input logic signed [SATW-1:0] v);
    logic signed [SATW-1:0] hi;
    logic signed [SATW-1:0] lo;
    hi = SATW'(SAT_HI);
    lo = SATW'(SAT_LO);
    if (v > hi) begin
      return hi[SW-1:0];
    end else if (v < lo) begin
      return lo[SW-1:0];
    end
    return v[SW-1:0];
  endfunction

endpackage

FILE: hdl/focft_ctrl.sv
// Valid-bit chain and per-stage load enables for the transform pipeline.
// Depends on focft_pkg.
module focft_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [focft_pkg::NSTAGE-1:0]  stage_en
);
  import focft_pkg::*;

  logic [NSTAGE-1:0] valid_r;
  logic [NSTAGE-1:0] valid_nxt;
  logic [NSTAGE:0]   rdy;

  always_comb begin
    rdy[NSTAGE] = out_ready;
    for (int i = NSTAGE - 1; i >= 0; i--) begin
      rdy[i] = !valid_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    valid_nxt[0] = rdy[0] ? in_valid : valid_r[0];
    for (int i = 1; i < NSTAGE; i++) begin
      valid_nxt[i] = rdy[i] ? valid_r[i-1] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign stage_en  = rdy[NSTAGE-1:0];
  assign in_ready  = rdy[0];
  assign out_valid = valid_r[NSTAGE-1];

endmodule

FILE: hdl/focft_front.sv
// Stages one to three: sine/cosine lookup, Clarke sums, constant and
// rotation products, then rounding to alpha/beta and inverse-Park x/y.
// Depends on focft_pkg.
module focft_front (
  input  logic                                 clk,
  input  logic [focft_pkg::FRONT_STAGES-1:0]   stage_en,
  input  focft_pkg::in_t                       in_data,
  output focft_pkg::mid_t                      mid_data
);
  import focft_pkg::*;

  logic [1:0]          quad;
  logic [FB-1:0]       frac;
  logic [FB+DB-1:0]    kprod;
  logic [IW-1:0]       k_lo;
  logic [IW-1:0]       k_hi;
  trig_t               tab_lo;
  trig_t               tab_hi;
  trig_t               sine_nxt;
  trig_t               cosine_nxt;

  trig_t               sine1_r;
  trig_t               cosine1_r;
  logic signed [UW-1:0] u_r;
  logic signed [VW-1:0] v_r;
  logic signed [SW-1:0] vd_r;
  logic signed [SW-1:0] vq_r;

  trig_t                sine2_r;
  trig_t                cosine2_r;
  logic signed [PUW-1:0] pu_r;
  logic signed [PVW-1:0] pv_r;
  logic signed [MW-1:0]  m_dc_r;
  logic signed [MW-1:0]  m_qs_r;
  logic signed [MW-1:0]  m_ds_r;
  logic signed [MW-1:0]  m_qc_r;

  logic signed [PUW-1:0] pu_sum;
  logic signed [PVW-1:0] pv_sum;
  logic signed [XSW-1:0] x_sum;
  logic signed [XSW-1:0] y_sum;
  mid_t                  mid_nxt;
  mid_t                  mid_r;

  assign quad   = in_data.rotor_angle[ANGLE_WIDTH-1 -: 2];
  assign frac   = in_data.rotor_angle[FB-1:0];
  assign kprod  = {{DB{1'b0}}, frac} * (FB+DB)'(SINE_TABLE_DEPTH);
  assign k_lo   = kprod[FB +: IW];
  assign k_hi   = IW'(SINE_TABLE_DEPTH) - k_lo;
  assign tab_lo = SINE_ROM[k_lo];
  assign tab_hi = SINE_ROM[k_hi];

  always_comb begin
    case (quad)
      QUAD_0: begin
        sine_nxt   = tab_lo;
        cosine_nxt = tab_hi;
      end
      QUAD_1: begin
        sine_nxt   = tab_hi;
        cosine_nxt = -tab_lo;
      end
      QUAD_2: begin
        sine_nxt   = -tab_lo;
        cosine_nxt = -tab_hi;
      end
      QUAD_3: begin
        sine_nxt   = -tab_hi;
        cosine_nxt = tab_lo;
      end
      default: begin
        sine_nxt   = '0;
        cosine_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      sine1_r   <= sine_nxt;
      cosine1_r <= cosine_nxt;
      u_r       <= (UW'(in_data.current_a) <<< 1) - UW'(in_data.current_b)
                   - UW'(in_data.current_c);
      v_r       <= VW'(in_data.current_b) - VW'(in_data.current_c);
      vd_r      <= in_data.volt_d;
      vq_r      <= in_data.volt_q;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      sine2_r   <= sine1_r;
      cosine2_r <= cosine1_r;
      pu_r      <= PUW'(u_r) * PUW'(K_SQRT_1_6);
      pv_r      <= PVW'(v_r) * PVW'(K_SQRT_1_2);
      m_dc_r    <= MW'(vd_r) * MW'(cosine1_r);
      m_qs_r    <= MW'(vq_r) * MW'(sine1_r);
      m_ds_r    <= MW'(vd_r) * MW'(sine1_r);
      m_qc_r    <= MW'(vq_r) * MW'(cosine1_r);
    end
  end

  assign pu_sum = pu_r + PUW'(RND_K);
  assign pv_sum = pv_r + PVW'(RND_K);
  assign x_sum  = XSW'(m_dc_r) - XSW'(m_qs_r) + XSW'(RND_T);
  assign y_sum  = XSW'(m_ds_r) + XSW'(m_qc_r) + XSW'(RND_T);

  always_comb begin
    mid_nxt.alpha  = pu_sum[Q_K +: XW];
    mid_nxt.beta   = pv_sum[Q_K +: XW];
    mid_nxt.volt_x = x_sum[Q_T +: XW];
    mid_nxt.volt_y = y_sum[Q_T +: XW];
    mid_nxt.sine   = sine2_r;
    mid_nxt.cosine = cosine2_r;
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid_data = mid_r;

endmodule

FILE: hdl/focft_back.sv
// Stages four to six: Park and inverse-Clarke products, rounding and
// saturation of d/q, then min-max offset injection on the phase commands.
// Depends on focft_pkg.
module focft_back (
  input  logic                                clk,
  input  logic [focft_pkg::BACK_STAGES-1:0]   stage_en,
  input  focft_pkg::mid_t                     mid_data,
  output focft_pkg::out_t                     out_data
);
  import focft_pkg::*;

  logic signed [PRW-1:0] p_ac_r;
  logic signed [PRW-1:0] p_bs_r;
  logic signed [PRW-1:0] p_bc_r;
  logic signed [PRW-1:0] p_as_r;
  logic signed [PKW-1:0] p_xa_r;
  logic signed [PKW-1:0] p_xb_r;
  logic signed [PKW-1:0] p_yb_r;

  logic signed [DSW-1:0] d_sum;
  logic signed [DSW-1:0] q_sum;
  logic signed [PKW-1:0] pa_sum;
  logic signed [PBW-1:0] pb_sum;
  logic signed [PBW-1:0] pc_sum;

  logic signed [SW-1:0]  d5_r;
  logic signed [SW-1:0]  q5_r;
  logic signed [PHW-1:0] pa_r;
  logic signed [PHW-1:0] pb_r;
  logic signed [PHW-1:0] pc_r;

  logic signed [PHW-1:0] mx;
  logic signed [PHW-1:0] mn;
  logic signed [DRW-1:0] da_sum;
  logic signed [DRW-1:0] db_sum;
  logic signed [DRW-1:0] dc_sum;
  out_t                  out_nxt;
  out_t                  out_r;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      p_ac_r <= PRW'(mid_data.alpha) * PRW'(mid_data.cosine);
      p_bs_r <= PRW'(mid_data.beta) * PRW'(mid_data.sine);
      p_bc_r <= PRW'(mid_data.beta) * PRW'(mid_data.cosine);
      p_as_r <= PRW'(mid_data.alpha) * PRW'(mid_data.sine);
      p_xa_r <= PKW'(mid_data.volt_x) * PKW'(K_SQRT_2_3);
      p_xb_r <= PKW'(mid_data.volt_x) * PKW'(K_SQRT_1_6);
      p_yb_r <= PKW'(mid_data.volt_y) * PKW'(K_SQRT_1_2);
    end
  end

  assign d_sum  = DSW'(p_ac_r) + DSW'(p_bs_r) + DSW'(RND_T);
  assign q_sum  = DSW'(p_bc_r) - DSW'(p_as_r) + DSW'(RND_T);
  assign pa_sum = p_xa_r + PKW'(RND_K);
  assign pb_sum = PBW'(p_yb_r) - PBW'(p_xb_r) + PBW'(RND_K);
  assign pc_sum = -PBW'(p_xb_r) - PBW'(p_yb_r) + PBW'(RND_K);

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      d5_r <= saturate(SATW'($signed(d_sum[DSW-1:Q_T])));
      q5_r <= saturate(SATW'($signed(q_sum[DSW-1:Q_T])));
      pa_r <= pa_sum[Q_K +: PHW];
      pb_r <= pb_sum[Q_K +: PHW];
      pc_r <= pc_sum[Q_K +: PHW];
    end
  end

  always_comb begin
    mx = (pa_r > pb_r) ? pa_r : pb_r;
    if (pc_r > mx) begin
      mx = pc_r;
    end
    mn = (pa_r < pb_r) ? pa_r : pb_r;
    if (pc_r < mn) begin
      mn = pc_r;
    end
  end

  assign da_sum = (DRW'(pa_r) <<< 1) - DRW'(mx) - DRW'(mn) + DRW'(1);
  assign db_sum = (DRW'(pb_r) <<< 1) - DRW'(mx) - DRW'(mn) + DRW'(1);
  assign dc_sum = (DRW'(pc_r) <<< 1) - DRW'(mx) - DRW'(mn) + DRW'(1);

  always_comb begin
    out_nxt.current_d = d5_r;
    out_nxt.current_q = q5_r;
    out_nxt.drive_a   = saturate(SATW'($signed(da_sum[DRW-1:1])));
    out_nxt.drive_b   = saturate(SATW'($signed(db_sum[DRW-1:1])));
    out_nxt.drive_c   = saturate(SATW'($signed(dc_sum[DRW-1:1])));
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

FILE: hdl/foc_frame_transforms_core.sv
// Top level of the FOC frame transform pipeline.
// Depends on focft_pkg, focft_ctrl, focft_front and focft_back.
//
// Usage:
//   in_valid/in_ready/in_data carry one control sample per transfer: three
//   phase currents, rotor angle (unsigned turns) and commanded d/q voltages.
//   out_valid/out_ready/out_data carry one result per sample, in order:
//   d/q currents (Park of power-invariant Clarke) and three phase voltage
//   commands (inverse Park, inverse Clarke, min-max offset injection), all
//   signed Q1.15 and saturated.
//   Throughput: one sample per cycle while out_ready is high, set by six
//   register stages each with its own valid bit; the multipliers sit in
//   stages two and four.
//   Stall: while out_ready is low, samples keep entering until every stage
//   holds one; in_ready then drops. Nothing is lost or repeated.
//   Reset (rst_n low, synchronous) clears the valid bits only; the data
//   registers are not reset, and there is no configuration.
module foc_frame_transforms_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  focft_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output focft_pkg::out_t  out_data
);
  import focft_pkg::*;

  logic [NSTAGE-1:0] stage_en;
  mid_t              mid_data;

  focft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stage_en  (stage_en)
  );

  focft_front u_front (
    .clk      (clk),
    .stage_en (stage_en[FRONT_STAGES-1:0]),
    .in_data  (in_data),
    .mid_data (mid_data)
  );

  focft_back u_back (
    .clk      (clk),
    .stage_en (stage_en[NSTAGE-1:FRONT_STAGES]),
    .mid_data (mid_data),
    .out_data (out_data)
  );

endmodule
